// ===== rtl/core/amcb_pkg.sv =====
package amcb_pkg;

  // Default vertex capacity of the adjacency store
  localparam int MAX_VERTICES_DEF = 64;

  // Field widths fixed by the request and result formats
  localparam int VIDX_W  = 6;
  localparam int VCNT_W  = 7;
  localparam int TOTAL_W = 12;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

  // Action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_CHECK  = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [VIDX_W-1:0] src_vertex;
    logic [VIDX_W-1:0] dst_vertex;
    logic              attacks;
  } in_req_t;

  typedef struct packed {
    logic               edge_was_present;
    logic [TOTAL_W-1:0] edge_total;
    logic               is_bipartite;
    logic               bad_index;
  } out_rsp_t;

  // Sequencer -> coloring unit
  typedef struct packed {
    logic start;   // clear coloring state
    logic pick;    // take next vertex to expand
    logic expand;  // fold neighbor row into coloring
  } color_ctrl_t;

  // Coloring unit -> sequencer
  typedef struct packed {
    logic any;       // a vertex is left to expand or to seed
    logic conflict;  // same-colored neighbor in the row being expanded
  } color_stat_t;

endpackage

// ===== rtl/core/amcb_ram.sv =====
module amcb_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/amcb_color_unit.sv =====
module amcb_color_unit #(
  parameter int MAX_VERTICES = amcb_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  amcb_pkg::color_ctrl_t           ctrl,
  input  logic [MAX_VERTICES-1:0]         nmask,
  input  logic [MAX_VERTICES-1:0]         nbr,
  output amcb_pkg::color_stat_t           stat,
  output logic [$clog2(MAX_VERTICES)-1:0] cur
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] colored_r, colored_nxt;
  logic [MAX_VERTICES-1:0] cval_r, cval_nxt;
  logic [MAX_VERTICES-1:0] pending_r, pending_nxt;
  logic                    ccur_r, ccur_nxt;
  logic [MAX_VERTICES-1:0] sel;
  logic [MAX_VERTICES-1:0] newv;
  logic                    from_pending;

  // Expand pending vertices first; otherwise seed the lowest uncolored one
  assign from_pending = |pending_r;
  assign sel          = from_pending ? pending_r : (nmask & ~colored_r);

  always_comb begin
    cur = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        cur = AW'(i);
      end
    end
  end

  assign newv          = nbr & ~colored_r;
  assign stat.any      = |sel;
  assign stat.conflict = |(nbr & colored_r & ~(cval_r ^ {MAX_VERTICES{ccur_r}}));

  always_comb begin
    colored_nxt = colored_r;
    cval_nxt    = cval_r;
    pending_nxt = pending_r;
    ccur_nxt    = ccur_r;
    priority if (ctrl.start) begin
      colored_nxt = '0;
      pending_nxt = '0;
    end else if (ctrl.pick) begin
      pending_nxt[cur] = 1'b0;
      if (from_pending) begin
        ccur_nxt = cval_r[cur];
      end else begin
        colored_nxt[cur] = 1'b1;
        cval_nxt[cur]    = 1'b0;
        ccur_nxt         = 1'b0;
      end
    end else if (ctrl.expand) begin
      colored_nxt = colored_r | newv;
      pending_nxt = pending_r | newv;
      cval_nxt    = ccur_r ? (cval_r & ~newv) : (cval_r | newv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colored_r <= '0;
      pending_r <= '0;
    end else begin
      colored_r <= colored_nxt;
      pending_r <= pending_nxt;
    end
    cval_r <= cval_nxt;
    ccur_r <= ccur_nxt;
  end

endmodule

// ===== rtl/core/adjacency_matrix_bipartite_checker.sv =====
// Graph store with bipartite check. Holds an undirected graph of up to MAX_VERTICES
// vertices as one adjacency row per vertex (present and attack bits) plus an edge
// count. Requests insert, remove or query one edge, or two-color the attack edges
// among the vertices below vertex_count. One request is handled at a time and every
// request yields one result. The row memory has one write and one registered read
// port: a bad-index request goes straight to the result register, a query or a no-op
// insert/remove reads the src row first, and an insert or remove also writes the src
// row and then the dst row (a self-loop only the one row). A check takes one memory
// read and one row merge in the coloring unit per vertex it reaches; it stops early
// on the first conflict. Row valid bits, cleared by reset, make the memory read as
// empty without a clearing pass.
module adjacency_matrix_bipartite_checker #(
  parameter int MAX_VERTICES = amcb_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  amcb_pkg::in_req_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output amcb_pkg::out_rsp_t             out_data,
  // vertex_count register
  input  logic                           cfg_we,
  input  logic [amcb_pkg::VCNT_W-1:0]    cfg_wdata
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int ROW_W = 2 * MAX_VERTICES;  // {attack, present}

  localparam logic [amcb_pkg::VCNT_W-1:0] MAXV = amcb_pkg::VCNT_W'(MAX_VERTICES);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_E_SRC  = 3'd1;  // row of src in hand
  localparam logic [2:0] ST_E_DST  = 3'd2;  // row of dst in hand
  localparam logic [2:0] ST_C_PICK = 3'd3;  // choose vertex, read its row
  localparam logic [2:0] ST_C_EXP  = 3'd4;  // merge row into coloring
  localparam logic [2:0] ST_FIN    = 3'd5;  // hand result to output register

  logic [2:0]                     state_r, state_nxt;
  amcb_pkg::in_req_t              req_r, req_nxt;
  logic [amcb_pkg::VCNT_W-1:0]    vcount_r;
  logic [amcb_pkg::TOTAL_W-1:0]   edge_cnt_r, edge_cnt_nxt;
  logic                           was_r, was_nxt;
  logic                           bip_r, bip_nxt;
  logic                           bad_r, bad_nxt;
  logic                           out_valid_r, out_valid_nxt;
  amcb_pkg::out_rsp_t             out_data_r, out_data_nxt;

  // Row memory and its per-row valid bits
  logic [MAX_VERTICES-1:0]        row_vld_r, row_vld_nxt;
  logic                           rd_vld_r;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]               ram_wdata, ram_rdata;
  logic [ROW_W-1:0]               row;
  logic [MAX_VERTICES-1:0]        row_pres, row_atk;

  logic [amcb_pkg::VCNT_W-1:0]    n_eff;
  logic [MAX_VERTICES-1:0]        nmask;
  logic [AW-1:0]                  src_a, dst_a;
  logic [MAX_VERTICES-1:0]        pos_bit;
  logic                           accept;
  logic                           is_ins, is_rem, modify, out_free;

  amcb_pkg::color_ctrl_t          cctrl;
  amcb_pkg::color_stat_t          cstat;
  logic [AW-1:0]                  ccur;

  // A vertex_count above capacity acts as the capacity
  assign n_eff = (vcount_r > MAXV) ? MAXV : vcount_r;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (amcb_pkg::VCNT_W'(i) < n_eff);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign src_a    = req_r.src_vertex[AW-1:0];
  assign dst_a    = req_r.dst_vertex[AW-1:0];

  // Rows never written read as empty
  assign row      = rd_vld_r ? ram_rdata : '0;
  assign row_pres = row[MAX_VERTICES-1:0];
  assign row_atk  = row[ROW_W-1:MAX_VERTICES];

  assign is_ins   = (req_r.action == amcb_pkg::ACT_INSERT);
  assign is_rem   = (req_r.action == amcb_pkg::ACT_REMOVE);
  // Only an insert of an absent edge or a remove of a present one touches the store
  assign modify   = (is_ins && !row_pres[dst_a]) || (is_rem && row_pres[dst_a]);
  assign out_free = !out_valid_r || !out_stall;

  // Bit of the opposite endpoint within the row being rewritten
  assign pos_bit  = {{(MAX_VERTICES-1){1'b0}}, 1'b1}
                    << ((state_r == ST_E_SRC) ? dst_a : src_a);

  // Rewritten row: insert sets present and sets/clears attack, remove clears both
  always_comb begin
    if (is_ins) begin
      ram_wdata = {req_r.attacks ? (row_atk | pos_bit) : (row_atk & ~pos_bit),
                   row_pres | pos_bit};
    end else begin
      ram_wdata = {row_atk & ~pos_bit, row_pres & ~pos_bit};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    edge_cnt_nxt  = edge_cnt_r;
    was_nxt       = was_r;
    bip_nxt       = bip_r;
    bad_nxt       = bad_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = src_a;
    ram_raddr     = in_data.src_vertex[AW-1:0];
    cctrl         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          was_nxt = 1'b0;
          bip_nxt = 1'b0;
          bad_nxt = 1'b0;
          priority if (in_data.action == amcb_pkg::ACT_CHECK) begin
            cctrl.start = 1'b1;
            state_nxt   = ST_C_PICK;
          end else if (({1'b0, in_data.src_vertex} >= n_eff) ||
                       ({1'b0, in_data.dst_vertex} >= n_eff)) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            // read of src row issued above
            state_nxt = ST_E_SRC;
          end
        end
      end

      ST_E_SRC: begin
        was_nxt   = row_pres[dst_a];
        ram_raddr = dst_a;
        if (modify) begin
          ram_we             = 1'b1;
          ram_waddr          = src_a;
          row_vld_nxt[src_a] = 1'b1;
          edge_cnt_nxt       = is_ins ? (edge_cnt_r + 1'b1) : (edge_cnt_r - 1'b1);
          // self-loop: a single entry, already written
          state_nxt          = (src_a == dst_a) ? ST_FIN : ST_E_DST;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_E_DST: begin
        ram_we             = 1'b1;
        ram_waddr          = dst_a;
        row_vld_nxt[dst_a] = 1'b1;
        state_nxt          = ST_FIN;
      end

      ST_C_PICK: begin
        ram_raddr = ccur;
        if (cstat.any) begin
          cctrl.pick = 1'b1;
          state_nxt  = ST_C_EXP;
        end else begin
          bip_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end

      ST_C_EXP: begin
        if (cstat.conflict) begin
          state_nxt = ST_FIN;
        end else begin
          cctrl.expand = 1'b1;
          state_nxt    = ST_C_PICK;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.edge_was_present = was_r;
          out_data_nxt.edge_total       = edge_cnt_r;
          out_data_nxt.is_bipartite     = bip_r;
          out_data_nxt.bad_index        = bad_r;
          state_nxt                     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= amcb_pkg::VCOUNT_RESET;
      edge_cnt_r  <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
    req_r      <= req_nxt;
    was_r      <= was_nxt;
    bip_r      <= bip_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
    rd_vld_r   <= row_vld_r[ram_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  amcb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Coloring unit sees attack edges among in-range vertices only
  amcb_color_unit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cctrl),
    .nmask (nmask),
    .nbr   (row_pres & row_atk & nmask),
    .stat  (cstat),
    .cur   (ccur)
  );

  // One request in flight: an accepted request blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted while previous one in flight");

  // Edge count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_cnt_r == $past(edge_cnt_r)) ||
    (edge_cnt_r == $past(edge_cnt_r) + 12'd1) ||
    (edge_cnt_r == $past(edge_cnt_r) - 12'd1))
    else $error("edge count jumped");

  // A passing check result never carries edge flags
  a_check_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_bipartite) |->
      (!out_data.bad_index && !out_data.edge_was_present))
    else $error("check result with edge flags set");

  // Memory is written only while an edge is being rewritten
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_E_SRC || state_r == ST_E_DST) && !bad_r)
    else $error("row write outside edge update");

endmodule

// ===== tb/tb_adjacency_matrix_bipartite_checker.sv =====
module tb_adjacency_matrix_bipartite_checker;
  import amcb_pkg::*;

  // Run shape
  localparam int ITEM_TARGET   = 1900;  // requests over the whole run
  localparam int CALM_TAIL     = 150;   // last requests/results run without idling
  localparam int CFG_SETTLE    = 4;     // idle cycles before a vertex_count write
  localparam int HOLDOFF_LEN   = 300;   // long output hold-off, in cycles
  localparam int DRAIN_CYCLES  = 2 * MAX_VERTICES_DEF + 12;
  // Worst quiet stretch: hold-off plus a full 64-vertex check plus bursts
  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;
  logic     cfg_we = 1'b0;
  logic [VCNT_W-1:0] cfg_wdata = '0;

  adjacency_matrix_bipartite_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Graph shadow: adjacency rows, edge count and the vertex_count register
  // ---------------------------------------------------------------------------
  logic [63:0]        shadow_present [64] = '{default: '0};
  logic [63:0]        shadow_attack  [64] = '{default: '0};
  logic [TOTAL_W-1:0] shadow_edges = '0;
  logic [VCNT_W-1:0]  shadow_vcount = VCOUNT_RESET;

  // BFS two-coloring over attack edges among vertices below n; seeds are taken
  // in index order and the first same-colored attack neighbor answers 0.
  function automatic bit attack_graph_two_colorable(int n);
    bit colored [64];
    bit color [64];
    int frontier [$];
    int cur;
    for (int v = 0; v < n; v++) begin
      if (colored[v]) continue;
      colored[v] = 1'b1;
      color[v]   = 1'b0;
      frontier   = {v};
      while (frontier.size() > 0) begin
        cur = frontier.pop_front();
        for (int j = 0; j < n; j++) begin
          if (!(shadow_present[cur][j] && shadow_attack[cur][j])) continue;
          if (!colored[j]) begin
            colored[j] = 1'b1;
            color[j]   = ~color[cur];
            frontier.push_back(j);
          end else if (color[j] == color[cur]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Applies one request to the shadow and returns the result it must produce
  function automatic out_rsp_t predict_graph_response(in_req_t r);
    out_rsp_t rsp;
    int n;
    n   = (shadow_vcount > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(shadow_vcount);
    rsp = '0;
    if (r.action == ACT_CHECK) begin
      rsp.is_bipartite = attack_graph_two_colorable(n);
    end else if (int'(r.src_vertex) >= n || int'(r.dst_vertex) >= n) begin
      // stored rows above a shrunk count stay as they are
      rsp.bad_index = 1'b1;
    end else begin
      rsp.edge_was_present = shadow_present[r.src_vertex][r.dst_vertex];
      if (r.action == ACT_INSERT && !rsp.edge_was_present) begin
        shadow_present[r.src_vertex][r.dst_vertex] = 1'b1;
        shadow_present[r.dst_vertex][r.src_vertex] = 1'b1;
        shadow_attack[r.src_vertex][r.dst_vertex]  = r.attacks;
        shadow_attack[r.dst_vertex][r.src_vertex]  = r.attacks;
        shadow_edges = shadow_edges + 1'b1;
      end else if (r.action == ACT_REMOVE && rsp.edge_was_present) begin
        shadow_present[r.src_vertex][r.dst_vertex] = 1'b0;
        shadow_present[r.dst_vertex][r.src_vertex] = 1'b0;
        shadow_attack[r.src_vertex][r.dst_vertex]  = 1'b0;
        shadow_attack[r.dst_vertex][r.src_vertex]  = 1'b0;
        shadow_edges = shadow_edges - 1'b1;
      end
    end
    rsp.edge_total = shadow_edges;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request backlog: requests and vertex_count writes in issue order
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                is_setting;
    logic [VCNT_W-1:0] setting;
    in_req_t           req;
  } backlog_entry_t;

  backlog_entry_t request_backlog [$];
  out_rsp_t       pending_graph_results [$];
  int             total_requests = 0;

  function automatic void add_request(logic [1:0] act, logic [VIDX_W-1:0] s,
                                      logic [VIDX_W-1:0] d, logic atk);
    backlog_entry_t e;
    e.is_setting     = 1'b0;
    e.setting        = '0;
    e.req.action     = act;
    e.req.src_vertex = s;
    e.req.dst_vertex = d;
    e.req.attacks    = atk;
    request_backlog.push_back(e);
    total_requests++;
  endfunction

  function automatic void add_setting(int vc);
    backlog_entry_t e;
    e.is_setting = 1'b1;
    e.setting    = vc[VCNT_W-1:0];
    e.req        = '0;
    request_backlog.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int issued = 0;
  int gap_left = 0;
  int idle_run = 0;
  int cfg_writes = 0;
  int checks_colorable = 0;
  int checks_odd = 0;
  int flagged_requests = 0;

  always @(posedge clk) begin
    bit             take;
    bit             nxt_valid;
    bit             nxt_we;
    in_req_t        nxt_req;
    out_rsp_t       pred;
    backlog_entry_t e;
    take      = in_valid && !in_stall;
    nxt_valid = in_valid && !take;
    nxt_req   = in_data;
    nxt_we    = 1'b0;
    e         = '{default: '0};
    if (take) begin
      pred = predict_graph_response(in_data);
      pending_graph_results.push_back(pred);
      issued++;
      if (in_data.action == ACT_CHECK) begin
        if (pred.is_bipartite) checks_colorable++;
        else checks_odd++;
      end
      if (pred.bad_index) flagged_requests++;
      // idle bursts, with quiet stretches and none near the end
      if (request_backlog.size() > CALM_TAIL && (issued / 80) % 3 != 1 &&
          $urandom_range(0, 5) == 0)
        gap_left = $urandom_range(1, 8);
    end
    // settle count: nothing in flight and nothing offered
    if (pending_graph_results.size() == 0 && !in_valid) idle_run++;
    else idle_run = 0;
    if (rst_n && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_backlog.size() > 0) begin
        if (request_backlog[0].is_setting) begin
          // register writes only with the block idle
          if (idle_run >= CFG_SETTLE) begin
            e             = request_backlog.pop_front();
            nxt_we        = 1'b1;
            shadow_vcount = e.setting;
            cfg_writes++;
            idle_run      = 0;
          end
        end else begin
          e         = request_backlog.pop_front();
          nxt_valid = 1'b1;
          nxt_req   = e.req;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_req;
    cfg_we   <= nxt_we;
    if (nxt_we) cfg_wdata <= e.setting;
  end

  // ---------------------------------------------------------------------------
  // Result monitor and output back-pressure
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int fail_count = 0;
  int stall_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk) begin
    out_rsp_t want;
    bit       nxt_stall;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (pending_graph_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: was=%0b total=%0d bip=%0b bad=%0b",
                   out_data.edge_was_present, out_data.edge_total,
                   out_data.is_bipartite, out_data.bad_index);
      end else begin
        want = pending_graph_results.pop_front();
        if (out_data.edge_was_present !== want.edge_was_present ||
            out_data.edge_total !== want.edge_total ||
            out_data.is_bipartite !== want.is_bipartite ||
            out_data.bad_index !== want.bad_index) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d mismatch: expected was=%0b total=%0d bip=%0b bad=%0b",
                     results_seen, want.edge_was_present, want.edge_total,
                     want.is_bipartite, want.bad_index);
            $display("  got was=%0b total=%0d bip=%0b bad=%0b",
                     out_data.edge_was_present, out_data.edge_total,
                     out_data.is_bipartite, out_data.bad_index);
          end
        end
      end
    end
    // one long hold-off mid-run so the block backs up into its request side
    if (!holdoff_done && total_requests > 0 && results_seen >= total_requests / 2) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
    end
    nxt_stall = 1'b0;
    if (holdoff_left > 0) begin
      holdoff_left--;
      nxt_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_stall = 1'b1;
    end else if (rst_n && results_seen < total_requests - CALM_TAIL &&
                 (results_seen / 100) % 3 != 2 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      nxt_stall  = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  // Watchdog: cycles with no handshake on any port
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d requests issued, %0d results seen", issued, results_seen);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int                vc;
    int                eff;
    int                len;
    int                r;
    int                pick;
    int                tries;
    bit                friendly;
    logic              atk;
    logic [VIDX_W-1:0] s;
    logic [VIDX_W-1:0] d;
    logic [63:0]       side_mask;
    logic [11:0]       made_pairs [$];

    // Directed: extremes, every action, kinds kept, self-loops, shrunk/zero/oversized
    add_setting(64);
    add_request(ACT_CHECK, 6'd0, 6'd0, 1'b0);     // empty graph colors
    add_request(ACT_INSERT, 6'd0, 6'd63, 1'b1);
    add_request(ACT_INSERT, 6'd63, 6'd0, 1'b0);   // already there, stays attack
    add_request(ACT_QUERY, 6'd63, 6'd0, 1'b1);
    add_request(ACT_INSERT, 6'd5, 6'd5, 1'b1);    // attack self-loop
    add_request(ACT_CHECK, 6'd63, 6'd63, 1'b1);   // fails on the loop
    add_request(ACT_REMOVE, 6'd5, 6'd5, 1'b0);
    add_request(ACT_INSERT, 6'd1, 6'd2, 1'b1);
    add_request(ACT_INSERT, 6'd2, 6'd3, 1'b1);
    add_request(ACT_INSERT, 6'd3, 6'd1, 1'b1);    // odd attack cycle
    add_request(ACT_CHECK, 6'd0, 6'd0, 1'b0);
    add_request(ACT_REMOVE, 6'd1, 6'd3, 1'b0);
    add_request(ACT_INSERT, 6'd1, 6'd3, 1'b0);    // plain edge closes the cycle
    add_request(ACT_CHECK, 6'd0, 6'd0, 1'b0);
    add_request(ACT_REMOVE, 6'd10, 6'd11, 1'b1);  // absent
    add_request(ACT_QUERY, 6'd20, 6'd21, 1'b0);   // absent
    add_setting(1);
    add_request(ACT_INSERT, 6'd0, 6'd0, 1'b1);
    add_request(ACT_INSERT, 6'd0, 6'd1, 1'b1);    // out of range
    add_request(ACT_CHECK, 6'd0, 6'd0, 1'b0);
    add_request(ACT_QUERY, 6'd63, 6'd0, 1'b0);    // stored but above the count
    add_setting(0);
    add_request(ACT_INSERT, 6'd0, 6'd0, 1'b0);
    add_request(ACT_CHECK, 6'd0, 6'd0, 1'b0);     // nothing to color
    add_setting(127);                             // clamps to the full store
    add_request(ACT_QUERY, 6'd63, 6'd0, 1'b0);
    add_request(ACT_REMOVE, 6'd0, 6'd0, 1'b1);
    add_request(ACT_CHECK, 6'd63, 6'd0, 1'b1);

    // Random phases: one vertex_count each, mostly small graphs. Friendly
    // phases clear earlier edges and keep attack edges across a random split,
    // so checks pass until a rare same-side attack edge breaks them.
    while (total_requests < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) vc = 0;
      else if (pick == 1) vc = 1;
      else if (pick == 2) vc = $urandom_range(65, 127);
      else if (pick < 5) vc = 64;
      else if (pick < 8) vc = $urandom_range(13, 63);
      else vc = $urandom_range(2, 12);
      add_setting(vc);
      eff       = (vc > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : vc;
      friendly  = 1'($urandom_range(0, 1));
      side_mask = {$urandom, $urandom};
      if (friendly) begin
        foreach (made_pairs[i])
          add_request(ACT_REMOVE, made_pairs[i][11:6], made_pairs[i][5:0],
                      1'($urandom_range(0, 1)));
        made_pairs.delete();
      end
      len = (eff == 0) ? 12 : $urandom_range(40, 120);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (eff == 0 || r < 4) begin
          // noise: any fields, often out of range
          add_request(2'($urandom_range(0, 3)), VIDX_W'($urandom_range(0, 63)),
                      VIDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          continue;
        end
        s = VIDX_W'($urandom_range(0, eff - 1));
        d = VIDX_W'($urandom_range(0, eff - 1));
        if (r < 16) begin
          add_request(ACT_CHECK, VIDX_W'($urandom_range(0, 63)),
                      VIDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end else if (r < 24) begin
          add_request(ACT_QUERY, s, d, 1'($urandom_range(0, 1)));
        end else if (r < 36) begin
          add_request(ACT_REMOVE, s, d, 1'($urandom_range(0, 1)));
        end else begin
          atk = ($urandom_range(0, 9) < 7);
          if (friendly && atk && $urandom_range(0, 29) != 0) begin
            tries = 0;
            while (tries < 8 && side_mask[s] == side_mask[d]) begin
              d = VIDX_W'($urandom_range(0, eff - 1));
              tries++;
            end
          end
          made_pairs.push_back({s, d});
          add_request(ACT_INSERT, s, d, atk);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (request_backlog.size() == 0 && pending_graph_results.size() == 0 && !in_valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += pending_graph_results.size();

    $display("run: %0d requests, %0d results, %0d vertex_count writes, %0d flagged bad index",
             issued, results_seen, cfg_writes, flagged_requests);
    $display("run: %0d checks two-colorable, %0d with an odd attack cycle",
             checks_colorable, checks_odd);
    $display("run: one long output hold-off with the request side backed up");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
